[sv/rrcs_pkg.sv]
package rrcs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int SLOT_IN_W = 4;
  localparam int ARR_W     = 16;
  localparam int QUANT_W   = 16;
  localparam int PCNT_W    = 5;
  localparam int KIND_W    = 2;
  localparam int ID_W      = 5;
  localparam int CLK_W     = 21;
  localparam int SUM_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_JOB  = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ACK  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RUN_LEN,
    S_RUN_COMMIT,
    S_TAT,
    S_WAIT,
    S_SUM,
    S_GAP,
    S_COPY,
    S_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;
    logic set_ack;
    logic load;
    logic copy_init;
    logic copy_step;
    logic scan_init;
    logic scan_step;
    logic run_len;
    logic run_commit;
    logic calc_tat;
    logic calc_wait;
    logic add_wait;
    logic gap_or_done;
    logic emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    req_e req;
    logic hit;
    logic sweep_end;
    logic from_zero;
    logic copy_done;
    logic finished;
  } sts_t;

endpackage

[sv/rrcs_ram.sv]
module rrcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rrcs_dp.sv]
module rrcs_dp #(
  parameter int MAX_JOBS  = rrcs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = rrcs_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rrcs_pkg::cmd_t                  cmd,
  output rrcs_pkg::sts_t                  sts,
  input  logic [rrcs_pkg::REQ_W-1:0]      req_type,
  input  logic [rrcs_pkg::SLOT_IN_W-1:0]  process_slot,
  input  logic [rrcs_pkg::ARR_W-1:0]      arrival_time,
  input  logic [rrcs_pkg::ARR_W-1:0]      burst_time,
  input  logic                            cfg_we,
  input  logic [rrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrcs_pkg::CFG_DAT_W-1:0]  cfg_data,
  output logic [rrcs_pkg::KIND_W-1:0]     slice_kind,
  output logic [rrcs_pkg::ID_W-1:0]       process_id,
  output logic [rrcs_pkg::CLK_W-1:0]      start_time,
  output logic [rrcs_pkg::CLK_W-1:0]      end_time,
  output logic                            job_finished,
  output logic [rrcs_pkg::CLK_W-1:0]      turnaround,
  output logic [rrcs_pkg::CLK_W-1:0]      waiting,
  output logic [rrcs_pkg::SUM_W-1:0]      total_turnaround,
  output logic [rrcs_pkg::SUM_W-1:0]      total_waiting
);
  import rrcs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int AW     = (TIME_BITS < ARR_W) ? TIME_BITS : ARR_W;
  localparam int PCW    = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
  localparam int SUM1_W = SUM_W + 1;

  // Latched item
  logic [REQ_W-1:0]     req_r;
  logic [SLOT_IN_W-1:0] slot_r;
  logic [ARR_W-1:0]     arr_r;
  logic [ARR_W-1:0]     bur_r;

  // Configuration
  logic [QUANT_W-1:0] quantum;
  logic [PCNT_W-1:0]  process_count;

  // Schedule state
  logic [CLK_W-1:0]  cur_time;
  logic [SLOT_W-1:0] scan_idx;
  logic [SUM_W-1:0]  tsum;
  logic [SUM_W-1:0]  wsum;

  // Sweep machinery
  logic [CNT_W-1:0]  ptr;
  logic              pipe_v;
  logic [SLOT_W-1:0] pipe_idx;
  logic              from_zero;
  logic              pending;
  logic [AW-1:0]     min_arr;

  // Selected job
  logic [SLOT_W-1:0] hit_idx;
  logic [AW-1:0]     hit_arr;
  logic [AW-1:0]     hit_bur;
  logic [AW-1:0]     hit_rem;
  logic [AW-1:0]     run_len;
  logic [AW-1:0]     rem_new;

  // Pending result
  logic [KIND_W-1:0] res_kind;
  logic [ID_W-1:0]   res_id;
  logic [CLK_W-1:0]  res_start;
  logic [CLK_W-1:0]  res_end;
  logic              res_fin;
  logic [CLK_W-1:0]  res_tat;
  logic [CLK_W-1:0]  res_wt;

  // Store ports
  logic [AW-1:0]     arr_rd;
  logic [AW-1:0]     bur_rd;
  logic [AW-1:0]     rem_rd;
  logic [SLOT_W-1:0] load_addr;
  logic              slot_ok;
  logic              rem_we;
  logic [SLOT_W-1:0] rem_waddr;
  logic [AW-1:0]     rem_wdata;

  logic [PCW-1:0]    pc_ext;
  logic [CNT_W-1:0]  cnt;
  logic              scan_lt;
  logic              issue;
  logic              copy_issue;
  logic              hit;
  logic              min_upd;
  logic [QUANT_W-1:0] q_eff;
  logic [AW-1:0]     run_sel;
  logic [CLK_W-1:0]  time_add;
  logic [CNT_W-1:0]  idx_next;
  logic [SUM1_W-1:0] tsum_add;
  logic [SUM1_W-1:0] wsum_add;

  assign pc_ext     = PCW'(process_count);
  assign cnt        = (pc_ext > PCW'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : CNT_W'(pc_ext);
  assign scan_lt    = CNT_W'(scan_idx) < cnt;
  assign issue      = ptr < cnt;
  assign copy_issue = ptr < CNT_W'(MAX_JOBS);
  assign hit        = pipe_v && (rem_rd != '0) && (CLK_W'(arr_rd) <= cur_time);
  assign min_upd    = cmd.scan_step && pipe_v && !hit && (rem_rd != '0) &&
                      (!pending || (arr_rd < min_arr));
  assign q_eff      = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign run_sel    = (QUANT_W'(hit_rem) < q_eff) ? hit_rem : AW'(q_eff);
  assign time_add   = cur_time + CLK_W'(run_len);
  assign idx_next   = CNT_W'(hit_idx) + CNT_W'(1);
  assign tsum_add   = SUM1_W'(tsum) + SUM1_W'(res_tat);
  assign wsum_add   = SUM1_W'(wsum) + SUM1_W'(res_wt);

  assign load_addr  = SLOT_W'(process_slot_r_ext(slot_r));
  assign slot_ok    = int'(slot_r) < MAX_JOBS;

  function automatic logic [SLOT_IN_W+8-1:0] process_slot_r_ext(
    input logic [SLOT_IN_W-1:0] s);
    return (SLOT_IN_W+8)'(s);
  endfunction

  assign rem_we    = (cmd.load && slot_ok) || (cmd.copy_step && pipe_v) || cmd.run_commit;
  assign rem_waddr = cmd.run_commit ? hit_idx : (cmd.copy_step ? pipe_idx : load_addr);
  assign rem_wdata = cmd.run_commit ? rem_new : (cmd.copy_step ? bur_rd : AW'(bur_r));

  assign sts.req       = req_e'(req_r);
  assign sts.hit       = hit;
  assign sts.sweep_end = !issue && !pipe_v;
  assign sts.from_zero = from_zero;
  assign sts.copy_done = !copy_issue && !pipe_v;
  assign sts.finished  = (rem_new == '0);

  rrcs_ram #(.WIDTH(AW), .DEPTH(MAX_JOBS)) u_arr_ram (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (load_addr),
    .wdata (AW'(arr_r)),
    .raddr (ptr[SLOT_W-1:0]),
    .rdata (arr_rd)
  );

  rrcs_ram #(.WIDTH(AW), .DEPTH(MAX_JOBS)) u_bur_ram (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (load_addr),
    .wdata (AW'(bur_r)),
    .raddr (ptr[SLOT_W-1:0]),
    .rdata (bur_rd)
  );

  rrcs_ram #(.WIDTH(AW), .DEPTH(MAX_JOBS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (ptr[SLOT_W-1:0]),
    .rdata (rem_rd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum       <= QUANT_W'(1);
      process_count <= PCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM: quantum <= cfg_data[QUANT_W-1:0];
        CFG_COUNT:   process_count <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and schedule state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time  <= '0;
      scan_idx  <= '0;
      tsum      <= '0;
      wsum      <= '0;
      ptr       <= '0;
      pipe_v    <= 1'b0;
      from_zero <= 1'b0;
      pending   <= 1'b0;
    end else begin
      if (cmd.copy_init) begin
        cur_time <= '0;
        scan_idx <= '0;
        tsum     <= '0;
        wsum     <= '0;
        ptr      <= '0;
        pipe_v   <= 1'b0;
      end
      if (cmd.copy_step) begin
        pipe_v <= copy_issue;
        if (copy_issue) begin
          ptr <= ptr + CNT_W'(1);
        end
      end
      if (cmd.scan_init) begin
        pipe_v  <= 1'b0;
        pending <= 1'b0;
        if (scan_lt) begin
          ptr       <= CNT_W'(scan_idx);
          from_zero <= (scan_idx == '0);
        end else begin
          ptr       <= '0;
          from_zero <= 1'b1;
          scan_idx  <= '0;
        end
      end
      if (cmd.scan_step) begin
        if (!issue && !pipe_v && !from_zero) begin
          // tail of the sweep found nothing: go again from slot 0
          ptr       <= '0;
          from_zero <= 1'b1;
          pending   <= 1'b0;
          scan_idx  <= '0;
        end else begin
          pipe_v <= issue;
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (min_upd) begin
            pending <= 1'b1;
          end
        end
      end
      if (cmd.run_len) begin
        scan_idx <= (idx_next >= cnt) ? '0 : SLOT_W'(idx_next);
      end
      if (cmd.run_commit) begin
        cur_time <= time_add;
      end
      if (cmd.gap_or_done && pending) begin
        cur_time <= CLK_W'(min_arr);
      end
      if (cmd.calc_wait) begin
        tsum <= tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
      end
      if (cmd.add_wait) begin
        wsum <= wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r  <= req_type;
      slot_r <= process_slot;
      arr_r  <= arrival_time;
      bur_r  <= burst_time;
    end
    if (cmd.copy_step || cmd.scan_step) begin
      pipe_idx <= ptr[SLOT_W-1:0];
    end
    if (min_upd) begin
      min_arr <= arr_rd;
    end
    if (cmd.scan_step && hit) begin
      hit_idx <= pipe_idx;
      hit_arr <= arr_rd;
      hit_bur <= bur_rd;
      hit_rem <= rem_rd;
    end
    if (cmd.run_len) begin
      run_len <= run_sel;
      rem_new <= hit_rem - run_sel;
    end
    if (cmd.set_ack) begin
      res_kind  <= KIND_ACK;
      res_id    <= '0;
      res_start <= '0;
      res_end   <= '0;
      res_fin   <= 1'b0;
      res_tat   <= '0;
      res_wt    <= '0;
    end
    if (cmd.run_commit) begin
      res_kind  <= KIND_JOB;
      res_id    <= ID_W'(idx_next);
      res_start <= cur_time;
      res_end   <= time_add;
      res_fin   <= (rem_new == '0);
      res_tat   <= '0;
      res_wt    <= '0;
    end
    if (cmd.calc_tat) begin
      res_tat <= cur_time - CLK_W'(hit_arr);
    end
    if (cmd.calc_wait) begin
      res_wt <= (res_tat >= CLK_W'(hit_bur)) ? (res_tat - CLK_W'(hit_bur)) : '0;
    end
    if (cmd.gap_or_done) begin
      res_kind  <= pending ? KIND_IDLE : KIND_DONE;
      res_id    <= '0;
      res_start <= cur_time;
      res_end   <= pending ? CLK_W'(min_arr) : cur_time;
      res_fin   <= 1'b0;
      res_tat   <= '0;
      res_wt    <= '0;
    end
    if (cmd.emit) begin
      slice_kind       <= res_kind;
      process_id       <= res_id;
      start_time       <= res_start;
      end_time         <= res_end;
      job_finished     <= res_fin;
      turnaround       <= res_tat;
      waiting          <= res_wt;
      total_turnaround <= (res_kind == KIND_ACK) ? '0 : tsum;
      total_waiting    <= (res_kind == KIND_ACK) ? '0 : wsum;
    end
  end

endmodule

[sv/rrcs_ctrl.sv]
module rrcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rrcs_pkg::sts_t sts,
  output rrcs_pkg::cmd_t cmd
);
  import rrcs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_LOAD: begin
            cmd.load    = 1'b1;
            cmd.set_ack = 1'b1;
            state_next  = S_EMIT;
          end
          REQ_ADVANCE: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          REQ_RESTART: begin
            cmd.copy_init = 1'b1;
            cmd.set_ack   = 1'b1;
            state_next    = S_COPY;
          end
          default: begin
            cmd.set_ack = 1'b1;
            state_next  = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          state_next = S_RUN_LEN;
        end else if (sts.sweep_end && sts.from_zero) begin
          state_next = S_GAP;
        end
      end
      S_RUN_LEN: begin
        cmd.run_len = 1'b1;
        state_next  = S_RUN_COMMIT;
      end
      S_RUN_COMMIT: begin
        cmd.run_commit = 1'b1;
        state_next     = sts.finished ? S_TAT : S_EMIT;
      end
      S_TAT: begin
        cmd.calc_tat = 1'b1;
        state_next   = S_WAIT;
      end
      S_WAIT: begin
        cmd.calc_wait = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.add_wait = 1'b1;
        state_next   = S_EMIT;
      end
      S_GAP: begin
        cmd.gap_or_done = 1'b1;
        state_next      = S_EMIT;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/round_robin_cpu_scheduler_unit.sv]
// Round-robin CPU schedule engine with a time quantum. Each input item is a
// load (store a job's arrival and burst in a slot), an advance (produce one
// Gantt slice) or a restart (rewind the clock and totals, reload every slot's
// remaining time from its burst); every item yields exactly one result item.
// One item is worked at a time. A load or unknown request goes from decode
// straight to the result register. An advance reads one job slot per cycle
// from the slot stores, starting at the saved sweep position: a job found in
// the sweep gives its slice after the run-length and commit steps (plus
// steps for turnaround, waiting and the two running totals when the job
// completes); when the tail of a sweep finds nothing a second sweep from
// slot 0 follows. A restart walks all MAX_JOBS slots copying burst into
// remaining. The result sits in an output register, so the next item can be
// taken while it waits. Configuration writes are always taken, but are meant
// for idle time.
module round_robin_cpu_scheduler_unit #(
  parameter int MAX_JOBS  = rrcs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = rrcs_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rrcs_pkg::REQ_W-1:0]      req_type,
  input  logic [rrcs_pkg::SLOT_IN_W-1:0]  process_slot,
  input  logic [rrcs_pkg::ARR_W-1:0]      arrival_time,
  input  logic [rrcs_pkg::ARR_W-1:0]      burst_time,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rrcs_pkg::KIND_W-1:0]     slice_kind,
  output logic [rrcs_pkg::ID_W-1:0]       process_id,
  output logic [rrcs_pkg::CLK_W-1:0]      start_time,
  output logic [rrcs_pkg::CLK_W-1:0]      end_time,
  output logic                            job_finished,
  output logic [rrcs_pkg::CLK_W-1:0]      turnaround,
  output logic [rrcs_pkg::CLK_W-1:0]      waiting,
  output logic [rrcs_pkg::SUM_W-1:0]      total_turnaround,
  output logic [rrcs_pkg::SUM_W-1:0]      total_waiting,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrcs_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import rrcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  // sequencer: one state per step of an item
  rrcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot stores, clock, sweep pointer, totals and the result register
  rrcs_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (req_type),
    .process_slot     (process_slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .slice_kind       (slice_kind),
    .process_id       (process_id),
    .start_time       (start_time),
    .end_time         (end_time),
    .job_finished     (job_finished),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting)
  );

  // an accepted item keeps the request side closed until its result is built
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while an item is in work");

  // acks carry nothing but their kind
  a_ack_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (slice_kind == KIND_ACK) |->
      (process_id == '0) && (total_turnaround == '0) && (total_waiting == '0))
    else $error("ack item with nonzero fields");

  // only a job slice can finish a job, and waiting never exceeds turnaround
  a_finish_job: assert property (@(posedge clk) disable iff (rst)
    out_valid && job_finished |->
      (slice_kind == KIND_JOB) && (process_id != '0) && (waiting <= turnaround))
    else $error("bad finishing slice");

  // a done item reports one point in time
  a_done_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && (slice_kind == KIND_DONE) |-> (start_time == end_time))
    else $error("done item with a time span");

endmodule

[sim/round_robin_cpu_scheduler_unit_tb.sv]
module round_robin_cpu_scheduler_unit_tb;
  import rrcs_pkg::*;

  // Opcode outside req_e: the block must ack it and change nothing.
  localparam logic [REQ_W-1:0]     REQ_UNKNOWN  = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 1000000;
  // Settle time after the last result; it outlasts a worst-case advance of two full sweeps.
  localparam int DRAIN_CYCLES = 60;
  localparam int SLOTS        = MAX_JOBS_DEF;

  // One Gantt slice as seen on the result channel.
  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    id;
    logic [CLK_W-1:0]   t_start;
    logic [CLK_W-1:0]   t_end;
    logic               fin;
    logic [CLK_W-1:0]   tat;
    logic [CLK_W-1:0]   wt;
    logic [SUM_W-1:0]   tat_sum;
    logic [SUM_W-1:0]   wt_sum;
  } slice_t;

  // Shadow scheduler: mirrors the block's job table, clock and sweep position
  // and queues the slice each accepted item must produce.
  class slice_book;
    logic [QUANT_W-1:0] quantum;
    logic [PCNT_W-1:0]  proc_count;
    logic [CLK_W-1:0]   clock_now;
    int                 scan_pos;
    logic [ARR_W-1:0]   arr_tab [SLOTS];
    logic [ARR_W-1:0]   burst_tab [SLOTS];
    logic [ARR_W-1:0]   left_tab [SLOTS];
    logic [SUM_W-1:0]   tat_total;
    logic [SUM_W-1:0]   wt_total;
    slice_t             due_q [$];
    kind_e              last_kind;
    int                 errors;

    function new();
      quantum    = 1;
      proc_count = 1;
      errors     = 0;
      last_kind  = KIND_ACK;
      for (int i = 0; i < SLOTS; i++) begin
        arr_tab[i]   = '0;
        burst_tab[i] = '0;
      end
      rewind();
    endfunction

    function void rewind();
      clock_now = '0;
      scan_pos  = 0;
      tat_total = '0;
      wt_total  = '0;
      for (int i = 0; i < SLOTS; i++) left_tab[i] = burst_tab[i];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_QUANTUM) quantum = data;
      else if (idx == CFG_COUNT) proc_count = data[PCNT_W-1:0];
    endfunction

    function int find_ready(int from, int lim);
      for (int i = from; i < lim; i++)
        if (left_tab[i] != 0 && arr_tab[i] <= clock_now) return i;
      return -1;
    endfunction

    // Totals stick at the 25-bit ceiling.
    function logic [SUM_W-1:0] clip_add(logic [SUM_W-1:0] a, logic [CLK_W-1:0] b);
      logic [SUM_W:0] t;
      t = a + b;
      return t[SUM_W] ? '1 : t[SUM_W-1:0];
    endfunction

    function slice_t next_slice();
      slice_t           s;
      int               lim;
      int               pick;
      bit               waiting_any;
      logic [ARR_W-1:0] soonest;
      logic [QUANT_W-1:0] q;
      logic [QUANT_W-1:0] run;
      logic [CLK_W-1:0] span;
      s = '0;
      s.kind = KIND_JOB;
      lim = (proc_count > SLOTS) ? SLOTS : proc_count;
      pick = -1;
      if (scan_pos < lim) pick = find_ready(scan_pos, lim);
      // tail of the sweep had nothing: sweep again from slot 0
      if (pick < 0 && scan_pos != 0) begin
        scan_pos = 0;
        pick = find_ready(0, lim);
      end
      if (pick < 0) begin
        waiting_any = 0;
        soonest = '0;
        for (int i = 0; i < lim; i++) begin
          if (left_tab[i] != 0) begin
            if (!waiting_any || arr_tab[i] < soonest) soonest = arr_tab[i];
            waiting_any = 1;
          end
        end
        s.t_start = clock_now;
        if (waiting_any) begin
          // idle gap up to the earliest pending arrival
          s.kind = KIND_IDLE;
          clock_now = soonest;
          scan_pos = 0;
        end else begin
          s.kind = KIND_DONE;
        end
        s.t_end   = clock_now;
        s.tat_sum = tat_total;
        s.wt_sum  = wt_total;
        return s;
      end
      q = (quantum == 0) ? 1 : quantum;
      run = (left_tab[pick] < q) ? left_tab[pick] : q;
      s.id = pick + 1;
      s.t_start = clock_now;
      clock_now = clock_now + run;
      left_tab[pick] = left_tab[pick] - run;
      scan_pos = (pick + 1 >= lim) ? 0 : pick + 1;
      if (left_tab[pick] == 0) begin
        span = clock_now - arr_tab[pick];
        s.fin = 1'b1;
        s.tat = span;
        s.wt  = (span >= burst_tab[pick]) ? span - burst_tab[pick] : '0;
        tat_total = clip_add(tat_total, s.tat);
        wt_total  = clip_add(wt_total, s.wt);
      end
      s.t_end   = clock_now;
      s.tat_sum = tat_total;
      s.wt_sum  = wt_total;
      return s;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [SLOT_IN_W-1:0] slot,
                               logic [ARR_W-1:0] arr, logic [ARR_W-1:0] burst);
      slice_t s;
      s = '0;
      s.kind = KIND_ACK;
      if (req == REQ_ADVANCE) begin
        s = next_slice();
      end else if (req == REQ_LOAD) begin
        arr_tab[slot]   = arr;
        burst_tab[slot] = burst;
        left_tab[slot]  = burst;
      end else if (req == REQ_RESTART) begin
        rewind();
      end
      last_kind = s.kind;
      due_q.push_back(s);
    endfunction

    function void cmp(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_slice(slice_t got);
      slice_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: slice_kind expected none actual %0h", $time, got.kind);
        return;
      end
      want = due_q.pop_front();
      cmp("slice_kind", want.kind, got.kind);
      cmp("process_id", want.id, got.id);
      cmp("start_time", want.t_start, got.t_start);
      cmp("end_time", want.t_end, got.t_end);
      cmp("job_finished", want.fin, got.fin);
      cmp("turnaround", want.tat, got.tat);
      cmp("waiting", want.wt, got.wt);
      cmp("total_turnaround", want.tat_sum, got.tat_sum);
      cmp("total_waiting", want.wt_sum, got.wt_sum);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [REQ_W-1:0]       req_type = '0;
  logic [SLOT_IN_W-1:0]   process_slot = '0;
  logic [ARR_W-1:0]       arrival_time = '0;
  logic [ARR_W-1:0]       burst_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [KIND_W-1:0]      slice_kind;
  logic [ID_W-1:0]        process_id;
  logic [CLK_W-1:0]       start_time;
  logic [CLK_W-1:0]       end_time;
  logic                   job_finished;
  logic [CLK_W-1:0]       turnaround;
  logic [CLK_W-1:0]       waiting;
  logic [SUM_W-1:0]       total_turnaround;
  logic [SUM_W-1:0]       total_waiting;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_data = '0;

  slice_book sb;
  int        items_sent = 0;
  int        cycle_count = 0;
  bit        tx_calm = 1'b0;  // sender runs back to back when set
  bit        rx_calm = 1'b0;  // receiver never stalls when set

  round_robin_cpu_scheduler_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .process_slot     (process_slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slice_kind       (slice_kind),
    .process_id       (process_id),
    .start_time       (start_time),
    .end_time         (end_time),
    .job_finished     (job_finished),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request driver. Entered and left at a falling edge. Valid is left high on
  // return so a back-to-back item needs no second assignment in the same step;
  // anything that lets time pass between items lowers it first.
  task automatic send_item(logic [REQ_W-1:0] req, logic [SLOT_IN_W-1:0] slot,
                           logic [ARR_W-1:0] arr, logic [ARR_W-1:0] burst);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type     <= req;
    process_slot <= slot;
    arrival_time <= arr;
    burst_time   <= burst;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, slot, arr, burst);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every queued slice has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Register write, only with the block idle.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per item, then take and check one slice.
  initial begin
    slice_t got;
    int     stall;
    do @(negedge clk); while (rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind    = kind_e'(slice_kind);
      got.id      = process_id;
      got.t_start = start_time;
      got.t_end   = end_time;
      got.fin     = job_finished;
      got.tat     = turnaround;
      got.wt      = waiting;
      got.tat_sum = total_turnaround;
      got.wt_sum  = total_waiting;
      sb.check_slice(got);
      @(negedge clk);
    end
  end

  initial begin
    int               n;
    int               r;
    int               extra;
    int               kind_sel;
    int               cnt_val;
    int               lim;
    int               phase_no;
    bit               wide;
    logic [CFG_DAT_W-1:0] cfg_word;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed ----
    // Fill every slot first: the job stores have no reset value.
    for (int k = 0; k < SLOTS; k++) begin
      case (k)
        0: send_item(REQ_LOAD, 4'd0, 16'd0, 16'd3);
        1: send_item(REQ_LOAD, 4'd1, 16'hFFFF, 16'hFFFF);  // latest arrival, longest burst
        2: send_item(REQ_LOAD, 4'd2, 16'd0, 16'd0);        // zero burst: never runs
        3: send_item(REQ_LOAD, 4'd3, 16'd5, 16'd1);
        default: send_item(REQ_LOAD, k[SLOT_IN_W-1:0], $urandom_range(0, 30),
                           $urandom_range(1, 9));
      endcase
    end
    send_item(REQ_ADVANCE, '0, '0, '0);              // reset config: slot 0, one tick
    send_item(REQ_UNKNOWN, '1, 16'hFFFF, 16'hFFFF);   // unknown opcode: ack only
    send_item(REQ_RESTART, '0, '0, '0);
    write_cfg(CFG_COUNT, 16'd0);                      // no active slots: done at once
    send_item(REQ_ADVANCE, '0, '0, '0);
    // quantum 0 acts as 1; slot 0 finishes, sweep wraps early, then an idle gap
    // up to slot 1's arrival, then slot 1 runs
    write_cfg(CFG_QUANTUM, 16'd0);
    write_cfg(CFG_COUNT, 16'd2);
    repeat (5) send_item(REQ_ADVANCE, '0, '0, '0);
    // widest quantum; count data all ones saturates to the slot count
    write_cfg(CFG_QUANTUM, 16'hFFFF);
    write_cfg(CFG_COUNT, 16'hFFFF);
    repeat (2) send_item(REQ_ADVANCE, '0, '0, '0);

    // ---- random phases ----
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      kind_sel = (phase_no == 0) ? 9 : $urandom_range(0, 9);
      phase_no++;
      if (kind_sel < 7) begin
        // Fresh schedule: new settings, new job set, restart, run to done.
        r = $urandom_range(0, 9);
        cfg_word = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                   (r == 2) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
        write_cfg(CFG_QUANTUM, cfg_word);
        r = $urandom_range(0, 9);
        cnt_val = (r == 0) ? 0 : (r == 1) ? SLOTS :
                  (r == 2) ? $urandom_range(17, 31) : $urandom_range(1, SLOTS);
        cfg_word = cnt_val;
        if (r == 3) cfg_word[CFG_DAT_W-1:PCNT_W] = $urandom;  // bits above the register
        write_cfg(CFG_COUNT, cfg_word);
        lim = (cnt_val > SLOTS) ? SLOTS : cnt_val;
        wide = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < lim; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 15);
            send_item(REQ_LOAD, k[SLOT_IN_W-1:0],
                      wide ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                      (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 40) :
                      $urandom_range(1, 8));
          end
        end
        send_item(REQ_RESTART, $urandom, $urandom, $urandom);
        // advances with some noise mixed in; stop a little past done
        n = 0;
        extra = $urandom_range(0, 2);
        while (n < 160) begin
          r = $urandom_range(0, 39);
          if (r == 0) begin
            send_item(REQ_LOAD, $urandom, $urandom_range(0, 40), $urandom_range(0, 8));
          end else if (r == 1) begin
            send_item(REQ_UNKNOWN, $urandom, $urandom, $urandom);
          end else if (r == 2 && $urandom_range(0, 3) == 0) begin
            send_item(REQ_RESTART, $urandom, $urandom, $urandom);
          end else begin
            send_item(REQ_ADVANCE, $urandom, $urandom, $urandom);
            if (sb.last_kind == KIND_DONE) begin
              if (extra == 0) break;
              extra--;
            end
          end
          n++;
        end
      end else if (kind_sel < 9) begin
        // Keep the schedule going under a new count: the saved sweep position
        // may now sit past the active slots.
        if ($urandom_range(0, 2) == 0)
          write_cfg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        write_cfg(CFG_COUNT, $urandom_range(1, SLOTS));
        if ($urandom_range(0, 1) == 0) write_cfg(CFG_QUANTUM, $urandom_range(1, 12));
        repeat ($urandom_range(8, 30)) send_item(REQ_ADVANCE, $urandom, $urandom, $urandom);
      end else begin
        // Long haul, no restart: huge bursts and quantum push the clock past
        // its 21-bit wrap and drive the totals into saturation.
        write_cfg(CFG_QUANTUM, $urandom_range(40000, 65535));
        write_cfg(CFG_COUNT, SLOTS);
        repeat (48) begin
          send_item(REQ_LOAD, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535));
          repeat ($urandom_range(1, 3)) send_item(REQ_ADVANCE, $urandom, $urandom, $urandom);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
